FILE: rtl/core/lfid_pkg.sv
// ----------------------------------------------------------------------------
// lfid_pkg
// Shared types and constants for the lowest-free-ID handle table.
// ----------------------------------------------------------------------------
package lfid_pkg;

  localparam int NUM_IDS     = 256;
  localparam int HANDLE_BITS = 32;
  localparam int ID_W        = 8;
  localparam int IDX_W       = $clog2(NUM_IDS);
  localparam int NF_W        = IDX_W + 1;
  localparam int GRP_SH      = 4;
  localparam int GRP_W       = 1 << GRP_SH;
  localparam int NUM_GRPS    = NUM_IDS / GRP_W;
  localparam int GRP_IDX_W   = IDX_W - GRP_SH;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_LOOKUP   = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_UNBLOCK  = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]             operation;
    logic [ID_W-1:0]        entry_id;
    logic [HANDLE_BITS-1:0] handle_in;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [ID_W-1:0]        id_out;
    logic [HANDLE_BITS-1:0] handle_out;
    logic                   was_unblocked;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic srch_grp;
    logic srch_bit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_search;
    logic grp_found;
  } dp_stat_t;

endpackage

FILE: rtl/core/lfid_ctrl.sv
// ----------------------------------------------------------------------------
// lfid_ctrl
// Sequencer: accept, execute, two-step free-ID search, result transfer.
// ----------------------------------------------------------------------------
module lfid_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lfid_pkg::dp_stat_t stat,
  output lfid_pkg::ctrl_cmd_t cmd
);
  import lfid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SGRP,
    S_SBIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_search ? S_SGRP : S_DONE;
      end
      S_SGRP: begin
        cmd.srch_grp = 1'b1;
        state_nxt    = stat.grp_found ? S_SBIT : S_DONE;
      end
      S_SBIT: begin
        cmd.srch_bit = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = !out_valid_r || !out_stall;
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/lfid_datapath.sv
// ----------------------------------------------------------------------------
// lfid_datapath
// Handle memory, blocked-mark memory, occupied bitmap, next-free pointer,
// group/bit first-free search and result registers.
// ----------------------------------------------------------------------------
module lfid_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  lfid_pkg::in_item_t  in_data,
  input  lfid_pkg::ctrl_cmd_t cmd,
  output lfid_pkg::dp_stat_t  stat,
  output lfid_pkg::out_item_t out_data
);
  import lfid_pkg::*;

  logic [HANDLE_BITS-1:0] mem [NUM_IDS];
  logic [HANDLE_BITS-1:0] rd_data_r;
  logic                   blk_mem [NUM_IDS];
  logic                   rd_blk_r;

  logic [2:0]             op_r;
  logic [ID_W-1:0]        id_r;
  logic [HANDLE_BITS-1:0] hdl_r;

  logic [NUM_IDS-1:0]     occ_r;
  logic [NF_W-1:0]        nf_r;
  logic [NF_W-1:0]        start_r;
  logic [GRP_IDX_W-1:0]   grp_r;

  status_t                res_status_r, res_status_nxt;
  logic [ID_W-1:0]        res_id_r, res_id_nxt;
  logic [HANDLE_BITS-1:0] res_handle_r, res_handle_nxt;
  logic                   res_unblk_r, res_unblk_nxt;
  out_item_t              out_r;

  logic [IDX_W-1:0]       id_idx;
  logic                   id_ok;
  logic                   nf_full;
  logic [GRP_IDX_W-1:0]   sg;
  logic [GRP_SH-1:0]      so;
  logic [GRP_W-1:0]       grp_bits;
  logic [NUM_GRPS-1:0]    gfree;
  logic [GRP_IDX_W-1:0]   first_grp;
  logic [GRP_W-1:0]       sel_bits;
  logic [GRP_SH-1:0]      first_bit;
  logic                   blk_we;
  logic [IDX_W-1:0]       blk_wa;
  logic                   blk_wd;

  assign id_idx  = id_r[IDX_W-1:0];
  assign id_ok   = (id_r != '0) && ((ID_W + 1)'(id_r) < (ID_W + 1)'(NUM_IDS)) && occ_r[id_idx];
  assign nf_full = (nf_r == NF_W'(NUM_IDS));
  assign sg      = start_r[IDX_W-1:GRP_SH];
  assign so      = start_r[GRP_SH-1:0];

  assign stat.need_search = (op_r == OP_REGISTER) && !nf_full;
  assign stat.grp_found   = |gfree;

  // group level: lowest group at or above the start that has a free ID
  always_comb begin
    gfree    = '0;
    grp_bits = '0;
    for (int g = 0; g < NUM_GRPS; g++) begin
      grp_bits = ~occ_r[g*GRP_W +: GRP_W];
      if (GRP_IDX_W'(g) == sg) grp_bits = grp_bits & ({GRP_W{1'b1}} << so);
      gfree[g] = (GRP_IDX_W'(g) >= sg) && (|grp_bits);
    end
    if (start_r[IDX_W]) gfree = '0;
    first_grp = '0;
    for (int g = NUM_GRPS - 1; g >= 0; g--) begin
      if (gfree[g]) first_grp = GRP_IDX_W'(g);
    end
  end

  // bit level inside the chosen group
  always_comb begin
    sel_bits = ~occ_r[{grp_r, {GRP_SH{1'b0}}} +: GRP_W];
    if (grp_r == sg) sel_bits = sel_bits & ({GRP_W{1'b1}} << so);
    first_bit = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (sel_bits[b]) first_bit = GRP_SH'(b);
    end
  end

  // blocked marks are only used for occupied entries; register writes zero
  always_comb begin
    blk_we = 1'b0;
    blk_wa = id_idx;
    blk_wd = 1'b0;
    if (cmd.exec) begin
      case (op_r)
        OP_REGISTER: begin
          blk_we = !nf_full;
          blk_wa = nf_r[IDX_W-1:0];
        end
        OP_LOOKUP: begin
          blk_we = id_ok;
          blk_wd = 1'b1;
        end
        OP_UNBLOCK: blk_we = id_ok;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_status_nxt = ST_NOT_FOUND;
    res_id_nxt     = '0;
    res_handle_nxt = '0;
    res_unblk_nxt  = 1'b0;
    case (op_r)
      OP_REGISTER: begin
        if (nf_full) begin
          res_status_nxt = ST_FULL;
        end else begin
          res_status_nxt = ST_OK;
          res_id_nxt     = ID_W'(nf_r);
        end
      end
      OP_LOOKUP: begin
        if (id_ok) begin
          res_status_nxt = ST_OK;
          res_handle_nxt = rd_data_r;
        end
      end
      OP_REMOVE: begin
        if (id_ok) begin
          res_status_nxt = ST_OK;
          res_unblk_nxt  = !rd_blk_r;
        end
      end
      OP_UNBLOCK: begin
        if (id_ok) res_status_nxt = ST_OK;
      end
      OP_CLEAR: res_status_nxt = ST_OK;
      default: res_status_nxt = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= mem[in_data.entry_id[IDX_W-1:0]];
      rd_blk_r  <= blk_mem[in_data.entry_id[IDX_W-1:0]];
    end
    if (cmd.exec && (op_r == OP_REGISTER) && !nf_full) begin
      mem[nf_r[IDX_W-1:0]] <= hdl_r;
    end
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.operation;
      id_r  <= in_data.entry_id;
      hdl_r <= in_data.handle_in;
    end
    if (cmd.srch_grp) grp_r <= first_grp;
    if (cmd.load_out) begin
      out_r.status        <= res_status_r;
      out_r.id_out        <= res_id_r;
      out_r.handle_out    <= res_handle_r;
      out_r.was_unblocked <= res_unblk_r;
    end
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_id_r     <= res_id_nxt;
      res_handle_r <= res_handle_nxt;
      res_unblk_r  <= res_unblk_nxt;
      start_r      <= nf_r + NF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      nf_r  <= NF_W'(1);
    end else if (cmd.exec) begin
      case (op_r)
        OP_REGISTER: begin
          if (!nf_full) occ_r[nf_r[IDX_W-1:0]] <= 1'b1;
        end
        OP_REMOVE: begin
          if (id_ok) begin
            occ_r[id_idx] <= 1'b0;
            if (NF_W'(id_r) < nf_r) nf_r <= NF_W'(id_r);
          end
        end
        OP_CLEAR: begin
          occ_r <= '0;
          nf_r  <= NF_W'(1);
        end
        default: ;
      endcase
    end else if (cmd.srch_grp) begin
      if (!(|gfree)) nf_r <= NF_W'(NUM_IDS);
    end else if (cmd.srch_bit) begin
      nf_r <= {1'b0, grp_r, first_bit};
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/core/lowest_free_id_allocator_top.sv
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_top
// Handle table with lowest-free ID allocation (register, lookup, remove,
// unblock, clear); ID 0 is reserved.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. The handle and blocked-mark memories
// are read at the accept edge; an operation then executes, moves its result
// into the output register once the previous result is no longer stalled,
// and returns to idle. A register that takes a free ID adds the first-free
// search over the occupied bitmap between execute and result transfer:
// 16-entry group select, then bit select inside the group; the bit select
// is skipped when it takes the last free ID. A register on a full table
// does no search. A finished result waits in its own output register, so
// the next operation is accepted while it is stalled. No clearing pass is
// needed after reset: the occupied bitmap is flip-flops cleared by reset and
// by the clear operation, and a blocked mark is written to zero whenever its
// entry is registered, so stale marks are never seen.
module lowest_free_id_allocator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lfid_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lfid_pkg::out_item_t out_data
);
  import lfid_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lfid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfid_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

FILE: rtl/core/lfid_checker.sv
// ----------------------------------------------------------------------------
// lfid_checker
// Port-level checks for the handle table, bound to the top level.
// ----------------------------------------------------------------------------
module lfid_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lfid_pkg::out_item_t out_data
);
  import lfid_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK) || (out_data.status == ST_NOT_FOUND) ||
                  (out_data.status == ST_FULL))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.id_out == '0) && (out_data.handle_out == '0) && !out_data.was_unblocked)
    else $error("failed operation returned nonzero fields");

  a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.id_out != '0) |->
      (out_data.handle_out == '0) && !out_data.was_unblocked)
    else $error("register result carries handle or unblock flag");

  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer accepted while an operation is in flight");

endmodule

bind lowest_free_id_allocator_top lfid_checker u_lfid_checker (.*);
